// ===== sv/mfqs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mfqs_pkg;

	localparam int TAG_W   = 8;
	localparam int NEED_W  = 16;
	localparam int TIME_W  = 32;
	localparam int SLICE_W = 8;
	localparam int LEVEL_W = 3;

	localparam logic [SLICE_W-1:0] BASE_SLICE_RESET = 8'd10;

	localparam logic OP_ARRIVE   = 1'b0;
	localparam logic OP_DISPATCH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_DEMOTED  = 3'd1,
		ST_FINISHED = 3'd2,
		ST_ABORTED  = 3'd3,
		ST_ACCEPTED = 3'd4,
		ST_REJECTED = 3'd5
	} status_t;

	// One entry of the task store.
	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [NEED_W-1:0] needed;
		logic [NEED_W-1:0] used;
		logic [TIME_W-1:0] arrival;
	} task_t;

	typedef struct packed {
		status_t            status;
		logic [TAG_W-1:0]   tag;
		logic [LEVEL_W-1:0] level;
		logic [NEED_W-1:0]  run_time;
		logic [TIME_W-1:0]  wait_total;
	} res_t;

	// Queue pointer updates requested by the sequencer.
	typedef struct packed {
		logic               pop;
		logic               push;
		logic [LEVEL_W-1:0] pop_lvl;
		logic [LEVEL_W-1:0] push_lvl;
	} lvl_cmd_t;

	typedef struct packed {
		logic               any;
		logic [LEVEL_W-1:0] top_lvl;
	} lvl_stat_t;

endpackage

`default_nettype wire

// ===== sv/mfqs_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mfqs_in_if;
	import mfqs_pkg::*;

	logic              valid;
	logic              ready;
	logic              opcode;
	logic [TAG_W-1:0]  task_tag;
	logic [NEED_W-1:0] needed_time;

	modport source (output valid, output opcode, output task_tag, output needed_time,
		input ready);
	modport sink (input valid, input opcode, input task_tag, input needed_time,
		output ready);
endinterface

`default_nettype wire

// ===== sv/mfqs_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mfqs_out_if;
	import mfqs_pkg::*;

	logic               valid;
	logic               ready;
	status_t            status;
	logic [TAG_W-1:0]   out_tag;
	logic [LEVEL_W-1:0] out_level;
	logic [NEED_W-1:0]  run_time;
	logic [TIME_W-1:0]  wait_total;

	modport source (output valid, output status, output out_tag, output out_level,
		output run_time, output wait_total, input ready);
	modport sink (input valid, input status, input out_tag, input out_level,
		input run_time, input wait_total, output ready);
endinterface

`default_nettype wire

// ===== sv/mfqs_level_ctl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mfqs_level_ctl #(
	parameter int LEVELS   = 5,
	parameter int CAPACITY = 32
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  mfqs_pkg::lvl_cmd_t                   cmd,
	output mfqs_pkg::lvl_stat_t                  stat,
	output logic [$clog2(CAPACITY)-1:0]          top_head,
	output logic [$clog2(CAPACITY)-1:0]          push_pos
);
	import mfqs_pkg::*;

	localparam int IW  = $clog2(CAPACITY);
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int LIW = $clog2(LEVELS);

	logic [IW-1:0] head_q [LEVELS];
	logic [IW-1:0] tail_q [LEVELS];
	logic [CW-1:0] cnt_q  [LEVELS];

	logic [LIW-1:0] top_idx;

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] x);
		wrap_inc = (x == IW'(CAPACITY - 1)) ? '0 : x + 1'b1;
	endfunction

	// Lowest-numbered nonempty level has priority.
	always_comb begin
		stat.any     = 1'b0;
		stat.top_lvl = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (cnt_q[i] != '0) begin
				stat.any     = 1'b1;
				stat.top_lvl = LEVEL_W'(i);
			end
		end
	end

	assign top_idx  = stat.top_lvl[LIW-1:0];
	assign top_head = head_q[top_idx];
	assign push_pos = tail_q[cmd.push_lvl[LIW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			for (int i = 0; i < LEVELS; i++) begin
				if (cmd.pop && cmd.pop_lvl == LEVEL_W'(i)) begin
					head_q[i] <= wrap_inc(head_q[i]);
				end
				if (cmd.push && cmd.push_lvl == LEVEL_W'(i)) begin
					tail_q[i] <= wrap_inc(tail_q[i]);
				end
				if ((cmd.pop && cmd.pop_lvl == LEVEL_W'(i))
						&& !(cmd.push && cmd.push_lvl == LEVEL_W'(i))) begin
					cnt_q[i] <= cnt_q[i] - 1'b1;
				end else if (!(cmd.pop && cmd.pop_lvl == LEVEL_W'(i))
						&& (cmd.push && cmd.push_lvl == LEVEL_W'(i))) begin
					cnt_q[i] <= cnt_q[i] + 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/multilevel_feedback_queue_scheduler_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Multilevel feedback queue scheduler. Each input item either enqueues a new task at
// level 0 (or rejects it if no entry is free) or dispatches one time slice of the head
// task of the highest-priority nonempty level, and produces exactly one result item.
// Task records live in a task memory of CAPACITY entries; the level queues and the list
// of recycled entries share one index memory. Both memories have registered reads and
// are accessed one after the other, which sets the item time: a dispatch reads the index
// memory, then the task memory, then writes both; an arrival may first pop a freed entry
// before writing; a rejected arrival or a dispatch with nothing queued touches neither
// memory. The result reaches the output register as the block returns to idle; input
// is taken again as soon as the result has moved there, even if it has not been taken
// yet. No clearing pass is needed after reset. base_slice must be written through
// cfg_we and cfg_wdata only while the block is idle; the block itself does not enforce
// this. Its reset value is 10.
module multilevel_feedback_queue_scheduler_core #(
	parameter int LEVELS   = 5,
	parameter int CAPACITY = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire [mfqs_pkg::SLICE_W-1:0]      cfg_wdata,
	mfqs_in_if.sink                          in_ch,
	mfqs_out_if.source                       out_ch
);
	import mfqs_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int RW = $clog2(LEVELS + 1);
	localparam int AW = RW + IW;
	localparam logic [RW-1:0] FREE_REGION = RW'(LEVELS);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_A_POP  = 7'b0000010,
		S_A_WR   = 7'b0000100,
		S_D_IDX  = 7'b0001000,
		S_D_TASK = 7'b0010000,
		S_D_UPD  = 7'b0100000,
		S_EMIT   = 7'b1000000
	} fsm_t;

	fsm_t state_q, state_d;

	logic [SLICE_W-1:0] base_slice_q;
	logic [TIME_W-1:0]  time_q;
	logic [CW-1:0]      fresh_q;
	logic [CW-1:0]      stack_cnt_q;
	logic               out_valid_q;

	logic [TAG_W-1:0]   tag_q;
	logic [NEED_W-1:0]  need_q;
	logic [IW-1:0]      slot_q;
	logic [LEVEL_W-1:0] lvl_q;
	logic [NEED_W-1:0]  run_q;
	res_t               res_q;
	res_t               out_q;

	// Index memory: level queues in regions 0 to LEVELS-1, recycled entries above them.
	logic [IW-1:0] idx_mem_q [0:(1 << AW) - 1];
	logic [IW-1:0] imem_rdata_q;
	logic          imem_re, imem_we;
	logic [AW-1:0] imem_raddr, imem_waddr;

	task_t         task_mem_q [0:CAPACITY-1];
	task_t         task_rd_q;
	task_t         tmem_wdata;
	logic          tmem_re, tmem_we;

	lvl_cmd_t      cmd;
	lvl_stat_t     lstat;
	logic [IW-1:0] top_head, push_pos;

	logic               in_acc, out_free, free_avail;
	logic [NEED_W-1:0]  slice, remain, run_d, new_used;
	logic [TIME_W-1:0]  wait_d;
	logic               unfinished, demote;
	logic [LEVEL_W-1:0] lvl_next;
	logic [IW-1:0]      stack_top;

	mfqs_level_ctl #(
		.LEVELS   (LEVELS),
		.CAPACITY (CAPACITY)
	) u_level_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (lstat),
		.top_head (top_head),
		.push_pos (push_pos)
	);

	assign in_acc     = in_ch.valid && in_ch.ready;
	assign out_free   = !out_valid_q || out_ch.ready;
	assign free_avail = (fresh_q != CW'(CAPACITY)) || (stack_cnt_q != '0);
	assign stack_top  = IW'(stack_cnt_q - 1'b1);

	assign slice    = NEED_W'(base_slice_q) << lvl_q;
	assign remain   = (task_rd_q.needed >= task_rd_q.used)
		? task_rd_q.needed - task_rd_q.used : '0;
	assign run_d    = (slice < remain) ? slice : remain;
	assign new_used = task_rd_q.used + run_q;
	assign unfinished = new_used < task_rd_q.needed;
	assign demote   = unfinished && (lvl_q != LEVEL_W'(LEVELS - 1));
	assign lvl_next = lvl_q + LEVEL_W'(1);
	// now + run - arrival - (used + run) reduces to the old time and old used time.
	assign wait_d   = time_q - task_rd_q.arrival - TIME_W'(task_rd_q.used);

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		imem_re    = 1'b0;
		imem_raddr = '0;
		imem_we    = 1'b0;
		imem_waddr = '0;
		tmem_re    = 1'b0;
		tmem_we    = 1'b0;
		tmem_wdata = task_rd_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (in_ch.opcode == OP_ARRIVE) begin
						if (!free_avail) begin
							state_d = S_EMIT;
						end else if (stack_cnt_q != '0) begin
							imem_re    = 1'b1;
							imem_raddr = {FREE_REGION, stack_top};
							state_d    = S_A_POP;
						end else begin
							state_d = S_A_WR;
						end
					end else if (!lstat.any) begin
						state_d = S_EMIT;
					end else begin
						imem_re     = 1'b1;
						imem_raddr  = {RW'(lstat.top_lvl), top_head};
						cmd.pop     = 1'b1;
						cmd.pop_lvl = lstat.top_lvl;
						state_d     = S_D_IDX;
					end
				end
			end
			S_A_POP: begin
				state_d = S_A_WR;
			end
			S_A_WR: begin
				tmem_we            = 1'b1;
				tmem_wdata.tag     = tag_q;
				tmem_wdata.needed  = need_q;
				tmem_wdata.used    = '0;
				tmem_wdata.arrival = time_q;
				cmd.push           = 1'b1;
				cmd.push_lvl       = '0;
				imem_we            = 1'b1;
				imem_waddr         = {RW'(0), push_pos};
				state_d            = S_EMIT;
			end
			S_D_IDX: begin
				tmem_re = 1'b1;
				state_d = S_D_TASK;
			end
			S_D_TASK: begin
				state_d = S_D_UPD;
			end
			S_D_UPD: begin
				tmem_we         = 1'b1;
				tmem_wdata.used = new_used;
				imem_we         = 1'b1;
				cmd.push_lvl    = lvl_next;
				if (demote) begin
					cmd.push   = 1'b1;
					imem_waddr = {RW'(lvl_next), push_pos};
				end else begin
					imem_waddr = {FREE_REGION, stack_cnt_q[IW-1:0]};
				end
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (imem_we) begin
			idx_mem_q[imem_waddr] <= slot_q;
		end
		if (imem_re) begin
			imem_rdata_q <= idx_mem_q[imem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (tmem_we) begin
			task_mem_q[slot_q] <= tmem_wdata;
		end
		if (tmem_re) begin
			task_rd_q <= task_mem_q[imem_rdata_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			base_slice_q <= BASE_SLICE_RESET;
			time_q       <= '0;
			fresh_q      <= '0;
			stack_cnt_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				base_slice_q <= cfg_wdata;
			end
			if (out_valid_q && out_ch.ready && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && in_ch.opcode == OP_ARRIVE && free_avail) begin
						if (stack_cnt_q != '0) begin
							stack_cnt_q <= stack_cnt_q - 1'b1;
						end else begin
							fresh_q <= fresh_q + 1'b1;
						end
					end
				end
				S_D_UPD: begin
					time_q <= time_q + TIME_W'(run_q);
					if (!demote) begin
						stack_cnt_q <= stack_cnt_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					tag_q  <= in_ch.task_tag;
					need_q <= in_ch.needed_time;
					lvl_q  <= lstat.top_lvl;
					slot_q <= fresh_q[IW-1:0];
					res_q  <= '{
						status:     (in_ch.opcode == OP_ARRIVE) ? ST_REJECTED : ST_IDLE,
						tag:        (in_ch.opcode == OP_ARRIVE) ? in_ch.task_tag : '0,
						level:      '0,
						run_time:   '0,
						wait_total: '0
					};
				end
			end
			S_A_POP: begin
				slot_q <= imem_rdata_q;
			end
			S_A_WR: begin
				res_q <= '{
					status:     ST_ACCEPTED,
					tag:        tag_q,
					level:      '0,
					run_time:   '0,
					wait_total: '0
				};
			end
			S_D_IDX: begin
				slot_q <= imem_rdata_q;
			end
			S_D_TASK: begin
				run_q <= run_d;
			end
			S_D_UPD: begin
				res_q <= '{
					status:     demote ? ST_DEMOTED
						: (unfinished ? ST_ABORTED : ST_FINISHED),
					tag:        task_rd_q.tag,
					level:      lvl_q,
					run_time:   run_q,
					wait_total: demote ? '0 : wait_d
				};
			end
			S_EMIT: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ch.ready       = (state_q == S_IDLE);
	assign out_ch.valid      = out_valid_q;
	assign out_ch.status     = out_q.status;
	assign out_ch.out_tag    = out_q.tag;
	assign out_ch.out_level  = out_q.level;
	assign out_ch.run_time   = out_q.run_time;
	assign out_ch.wait_total = out_q.wait_total;

endmodule

`default_nettype wire
